[rtl/core/three_motor_pd_speed_loop_defines.svh]
// Assertion macros used by the speed loop RTL.
`ifndef THREE_MOTOR_PD_SPEED_LOOP_DEFINES_SVH
`define THREE_MOTOR_PD_SPEED_LOOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define TMPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define TMPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tmpd_pkg.sv]
package tmpd_pkg;

  localparam int NUM_MOTORS = 3;
  localparam int PWM_PERIOD_DEF = 1000;

  localparam int MODE_W  = 2;
  localparam int MOTOR_W = 2;
  localparam int VALUE_W = 14;
  localparam int WIDTH_W = 10;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W   = 16;
  localparam int ERR_W   = 18;

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TARGET = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MOVING = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN_OTHERS = 2'd3;

  localparam logic [CFG_W-1:0] WINDOW_TICKS_RST  = 16'd50;
  localparam logic [CFG_W-1:0] P_GAIN_RST        = 16'd77;
  localparam logic [CFG_W-1:0] D_GAIN_FIRST_RST  = 16'd768;
  localparam logic [CFG_W-1:0] D_GAIN_OTHERS_RST = 16'd1536;

  typedef struct packed {
    logic [CFG_W-1:0] window_ticks;
    logic [CFG_W-1:0] p_gain;
    logic [CFG_W-1:0] d_gain_first;
    logic [CFG_W-1:0] d_gain_others;
  } cfg_t;

endpackage

[rtl/core/tmpd_in_if.sv]
interface tmpd_in_if
  import tmpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [MOTOR_W-1:0] motor;
  logic [VALUE_W-1:0] value;

  modport source (output valid, mode, motor, value, input ready);
  modport sink   (input valid, mode, motor, value, output ready);
endinterface

[rtl/core/tmpd_out_if.sv]
interface tmpd_out_if
  import tmpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               updated;
  logic [WIDTH_W-1:0] width_first;
  logic [WIDTH_W-1:0] width_second;
  logic [WIDTH_W-1:0] width_third;

  modport source (output valid, updated, width_first, width_second, width_third,
                  input ready);
  modport sink   (input valid, updated, width_first, width_second, width_third,
                  output ready);
endinterface

[rtl/core/three_motor_pd_speed_loop.sv]
// A request waits in the input register, passes through the combinational PD logic
// and is held as a result in the result register. Throughput: one request per cycle
// while the result side is not stalled; the two registers buffer both channels' data.
// Reset (rst_n low at a clock edge, synchronous): config registers take their defaults,
// all motor state, the window counter and the moving flag are cleared, channels empty.
`include "three_motor_pd_speed_loop_defines.svh"

module three_motor_pd_speed_loop
  import tmpd_pkg::*;
#(
  parameter int PWM_PERIOD = PWM_PERIOD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tmpd_in_if.sink              in_ch,
  tmpd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // The drive level is stored just wide enough to hold the full PWM period.
  localparam int DRV_W = $clog2(PWM_PERIOD + 1);
  localparam logic [DRV_W-1:0] DRV_MAX = DRV_W'(PWM_PERIOD);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  cfg_t cfg;

  tmpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // Input register: holds one accepted request until the result register is free.
  logic               s1_vld_r;
  logic               s1_vld_nxt;
  logic [MODE_W-1:0]  s1_mode_r;
  logic [MOTOR_W-1:0] s1_motor_r;
  logic [VALUE_W-1:0] s1_value_r;

  // Result register.
  logic               out_vld_r;
  logic               out_vld_nxt;
  logic               out_upd_r;
  logic [WIDTH_W-1:0] out_w_r [NUM_MOTORS];

  // Motor and window state.
  logic [CNT_W-1:0]        cnt_r    [NUM_MOTORS];
  logic [CNT_W-1:0]        cnt_nxt  [NUM_MOTORS];
  logic signed [ERR_W-1:0] perr_r   [NUM_MOTORS];
  logic signed [ERR_W-1:0] perr_nxt [NUM_MOTORS];
  logic [DRV_W-1:0]        drv_r    [NUM_MOTORS];
  logic [DRV_W-1:0]        drv_nxt  [NUM_MOTORS];
  logic [VALUE_W-1:0]      tgt_r    [NUM_MOTORS];
  logic [VALUE_W-1:0]      tgt_nxt  [NUM_MOTORS];
  logic [CNT_W-1:0]        win_r;
  logic [CNT_W-1:0]        win_nxt;
  logic                    moving_r;
  logic                    moving_nxt;

  // Outputs of the per-motor regulator math.
  logic signed [ERR_W-1:0] calc_err [NUM_MOTORS];
  logic [DRV_W-1:0]        calc_drv [NUM_MOTORS];

  logic               adv;
  logic               proc;
  logic               in_acc;
  logic [CNT_W-1:0]   win_inc;
  logic               win_hit;
  logic               upd_nxt;
  logic [DRV_W-1:0]   width_full [NUM_MOTORS];

  // The input register may move on whenever the result register is empty or being drained.
  // A new request is taken whenever the input register is empty or is moving on.
  assign adv    = !out_vld_r || out_ch.ready;
  assign proc   = s1_vld_r && adv;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_vld_r || adv;

  assign s1_vld_nxt  = in_acc || (s1_vld_r && !adv);
  assign out_vld_nxt = proc || (out_vld_r && !out_ch.ready);

  // Each motor gets its own copy of the PD arithmetic; the first motor (index zero) has its own D gain.
  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_motor
    tmpd_pd_calc #(
      .PWM_PERIOD(PWM_PERIOD),
      .DRV_W     (DRV_W)
    ) u_calc (
      .target   (tgt_r[g]),
      .count    (cnt_r[g]),
      .prev_err (perr_r[g]),
      .drive    (drv_r[g]),
      .p_gain   (cfg.p_gain),
      .d_gain   ((g == 0) ? cfg.d_gain_first : cfg.d_gain_others),
      .err      (calc_err[g]),
      .drive_nxt(calc_drv[g])
    );
  end

  // The window counter wraps at 65536, so a window length of zero matches once per wrap.
  assign win_inc = win_r + CNT_W'(1);
  assign win_hit = (win_inc == cfg.window_ticks);
  assign upd_nxt = proc && (s1_mode_r == MODE_TICK) && win_hit && moving_r;

  always_comb begin
    win_nxt    = win_r;
    moving_nxt = moving_r;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      perr_nxt[i] = perr_r[i];
      drv_nxt[i]  = drv_r[i];
      tgt_nxt[i]  = tgt_r[i];
    end
    if (proc) begin
      unique case (s1_mode_r)
        MODE_TICK: begin
          win_nxt = win_hit ? '0 : win_inc;
          if (upd_nxt) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
              cnt_nxt[i]  = '0;
              perr_nxt[i] = calc_err[i];
              drv_nxt[i]  = calc_drv[i];
            end
          end
        end
        MODE_PULSE: begin
          // Motor index three matches no motor and is dropped.
          for (int i = 0; i < NUM_MOTORS; i++) begin
            if (s1_motor_r == MOTOR_W'(i) && cnt_r[i] != CNT_MAX) begin
              cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
            end
          end
        end
        MODE_TARGET: begin
          for (int i = 0; i < NUM_MOTORS; i++) begin
            if (s1_motor_r == MOTOR_W'(i)) begin
              tgt_nxt[i] = s1_value_r;
              // A zero target stops the motor and forgets its history.
              if (s1_value_r == '0) begin
                cnt_nxt[i]  = '0;
                perr_nxt[i] = '0;
                drv_nxt[i]  = '0;
              end
            end
          end
        end
        MODE_MOVING: begin
          moving_nxt = s1_value_r[0];
        end
        default: begin
          win_nxt = win_r;
        end
      endcase
    end
  end

  // Widths always reflect the drive levels after this request has taken effect.
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      width_full[i] = DRV_MAX - drv_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      win_r     <= '0;
      moving_r  <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        cnt_r[i]  <= '0;
        perr_r[i] <= '0;
        drv_r[i]  <= '0;
        tgt_r[i]  <= '0;
      end
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      win_r     <= win_nxt;
      moving_r  <= moving_nxt;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        perr_r[i] <= perr_nxt[i];
        drv_r[i]  <= drv_nxt[i];
        tgt_r[i]  <= tgt_nxt[i];
      end
    end
  end

  // Payload registers load only with their handshake and need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_ch.mode;
      s1_motor_r <= in_ch.motor;
      s1_value_r <= in_ch.value;
    end
    if (proc) begin
      out_upd_r <= upd_nxt;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        out_w_r[i] <= WIDTH_W'(width_full[i]);
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.updated      = out_upd_r;
  assign out_ch.width_first  = out_w_r[0];
  assign out_ch.width_second = out_w_r[1];
  assign out_ch.width_third  = out_w_r[2];

  // Drive levels never leave the range of the PWM period.
  `TMPD_ASSERT_NOW(a_drv_range, clk, rst_n, 1'b1, (drv_r[0] <= DRV_MAX) && (drv_r[1] <= DRV_MAX) && (drv_r[2] <= DRV_MAX), "drive level above PWM period")
  // An update is only ever caused by a tick while the moving flag is set.
  `TMPD_ASSERT_NOW(a_upd_src, clk, rst_n, upd_nxt, (s1_mode_r == MODE_TICK) && moving_r && win_hit, "update without a moving tick")
  // After an update, all pulse counts start again from zero.
  `TMPD_ASSERT_NEXT(a_upd_clear, clk, rst_n, upd_nxt, (cnt_r[0] == '0) && (cnt_r[1] == '0) && (cnt_r[2] == '0), "pulse counts not cleared by update")
  // The block takes a request whenever the result side is not stalled.
  `TMPD_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_vld_r || out_ch.ready, in_ch.ready, "request refused while result side is free")

endmodule

[rtl/core/tmpd_cfg.sv]
module tmpd_cfg
  import tmpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_WINDOW_TICKS:  cfg_nxt.window_ticks  = cfg_wdata;
        REG_P_GAIN:        cfg_nxt.p_gain        = cfg_wdata;
        REG_D_GAIN_FIRST:  cfg_nxt.d_gain_first  = cfg_wdata;
        REG_D_GAIN_OTHERS: cfg_nxt.d_gain_others = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks  <= WINDOW_TICKS_RST;
      cfg_r.p_gain        <= P_GAIN_RST;
      cfg_r.d_gain_first  <= D_GAIN_FIRST_RST;
      cfg_r.d_gain_others <= D_GAIN_OTHERS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/tmpd_pd_calc.sv]
module tmpd_pd_calc
  import tmpd_pkg::*;
#(
  parameter int PWM_PERIOD = PWM_PERIOD_DEF,
  parameter int DRV_W      = $clog2(PWM_PERIOD + 1)
) (
  input  logic [VALUE_W-1:0]     target,
  input  logic [CNT_W-1:0]       count,
  input  logic signed [ERR_W-1:0] prev_err,
  input  logic [DRV_W-1:0]       drive,
  input  logic [CFG_W-1:0]       p_gain,
  input  logic [CFG_W-1:0]       d_gain,
  output logic signed [ERR_W-1:0] err,
  output logic [DRV_W-1:0]       drive_nxt
);

  localparam int GAIN_W = CFG_W + 1;
  localparam int DE_W   = ERR_W + 1;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int DP_W   = GAIN_W + DE_W;
  localparam int SUM_W  = DP_W + 1;
  localparam int U_W    = SUM_W - 8;
  localparam int ND_W   = U_W + 1;
  localparam logic signed [ND_W-1:0] PERIOD_S = ND_W'(PWM_PERIOD);

  logic signed [DE_W-1:0]  de;
  logic signed [PP_W-1:0]  p_prod;
  logic signed [DP_W-1:0]  d_prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [U_W-1:0]   u;
  logic signed [ND_W-1:0]  nd;

  assign err    = $signed({{(ERR_W-VALUE_W){1'b0}}, target})
                - $signed({{(ERR_W-CNT_W){1'b0}}, count});
  assign de     = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});
  assign p_prod = $signed({1'b0, p_gain}) * err;
  assign d_prod = $signed({1'b0, d_gain}) * de;
  assign sum    = $signed({{(SUM_W-PP_W){p_prod[PP_W-1]}}, p_prod})
                + $signed({d_prod[DP_W-1], d_prod});
  // Dropping the low eight bits of a two's complement value floors it.
  assign u      = sum[SUM_W-1:8];
  assign nd     = $signed({{(ND_W-DRV_W){1'b0}}, drive}) + $signed({u[U_W-1], u});

  always_comb begin
    if (nd < 0) begin
      drive_nxt = '0;
    end else if (nd > PERIOD_S) begin
      drive_nxt = DRV_W'(PWM_PERIOD);
    end else begin
      drive_nxt = nd[DRV_W-1:0];
    end
  end

endmodule
